@@ hw/rtl/clb_pkg.sv @@
package clb_pkg;

  localparam int MaxSegments = 63;
  localparam int FracBits    = 16;
  localparam int CntW        = 6;
  localparam int TW          = FracBits + 1;

  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd0;
  localparam logic [1:0] REG_LINE_COLOR    = 2'd1;
  localparam logic [1:0] REG_LINE_LIFETIME = 2'd2;
  localparam logic [1:0] REG_DRAW_ENABLE   = 2'd3;

  typedef logic signed [31:0] fx_t;
  typedef fx_t [2:0] vec_t;

  typedef struct packed {
    vec_t [3:0]        pts;
    logic [CntW-1:0]   n;
    logic [TW-1:0]     q;
    logic [CntW-1:0]   r;
    logic [31:0]       color;
    logic [31:0]       life;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_link_t;

  function automatic fx_t lerp(input fx_t a, input fx_t b, input logic [FracBits-1:0] t);
    logic signed [32:0]          diff;
    logic signed [33+FracBits:0] prod;
    diff = 33'(b) - 33'(a);
    prod = diff * $signed({1'b0, t});
    return a + prod[31+FracBits:FracBits];
  endfunction

endpackage

@@ hw/rtl/clb_front.sv @@
module clb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  clb_pkg::vec_t [3:0] pts,
  output clb_pkg::job_link_t link,
  input  logic               link_pop
);
  import clb_pkg::*;

  logic [CntW-1:0] n_r;
  logic [TW-1:0]   q_r;
  logic [CntW-1:0] rem_r;
  logic [31:0]     color_r, life_r;
  logic            en_r;
  logic            busy_r;
  logic [4:0]      cnt_r;
  logic [CntW:0]   rem_sh;
  logic            ge;

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_q_r;
  logic       accept, store;

  assign rem_sh = {rem_r, q_r[TW-1]};
  assign ge     = rem_sh >= {1'b0, n_r};

  assign full   = busy_r || (cnt_q_r == 2'd2);
  assign accept = push && !full;
  assign store  = accept && en_r;

  assign link.valid = cnt_q_r != 2'd0;
  assign link.job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= CntW'(16);
      q_r     <= TW'(4096);
      rem_r   <= '0;
      color_r <= 32'hFFFF_FFFF;
      life_r  <= '0;
      en_r    <= 1'b1;
      busy_r  <= 1'b0;
      cnt_r   <= '0;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_q_r <= '0;
    end else begin
      if (busy_r) begin
        rem_r <= ge ? CntW'(rem_sh - {1'b0, n_r}) : rem_sh[CntW-1:0];
        q_r   <= {q_r[TW-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) busy_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SEGMENT_COUNT: begin
            n_r    <= cfg_data[CntW-1:0];
            q_r    <= TW'(1) << FracBits;
            rem_r  <= '0;
            cnt_r  <= 5'(TW);
            busy_r <= 1'b1;
          end
          REG_LINE_COLOR:    color_r <= cfg_data;
          REG_LINE_LIFETIME: life_r  <= cfg_data;
          REG_DRAW_ENABLE:   en_r    <= cfg_data[0];
          default: ;
        endcase
      end
      if (store) wp_r <= !wp_r;
      if (link_pop) rp_r <= !rp_r;
      cnt_q_r <= cnt_q_r + {1'b0, store} - {1'b0, link_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem_r[wp_r] <= '{pts: pts, n: n_r, q: q_r, r: rem_r, color: color_r, life: life_r};
    end
  end

endmodule

@@ hw/rtl/clb_back.sv @@
module clb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  clb_pkg::job_link_t link,
  output logic               link_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output clb_pkg::vec_t      out_start,
  output clb_pkg::vec_t      out_end,
  output logic [31:0]        out_color,
  output logic [31:0]        out_life,
  output logic               out_last
);
  import clb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_L1, S_L2, S_L3, S_EMIT, S_LAST} state_t;

  state_t          state_r;
  job_t            job_r;
  vec_t            prev_r, cur_r;
  vec_t            a_r, b_r, e_r, d_r, f_r;
  logic [TW-1:0]   t_r;
  logic [CntW-1:0] racc_r, i_r;
  logic            ov_r;
  logic            slot_free;
  logic            load;
  logic [CntW:0]   rsum;
  logic            wrap;
  logic [FracBits-1:0] t;

  assign t         = t_r[FracBits-1:0];
  assign slot_free = !ov_r || out_pop;
  assign load      = slot_free && (state_r inside {S_EMIT, S_LAST});
  assign out_empty = !ov_r;
  assign link_pop  = (state_r == S_IDLE) && link.valid;
  assign rsum      = {1'b0, racc_r} + {1'b0, job_r.r};
  assign wrap      = rsum >= {1'b0, job_r.n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_pop && ov_r) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (link.valid) begin
            job_r   <= link.job;
            prev_r  <= link.job.pts[0];
            t_r     <= '0;
            racc_r  <= '0;
            i_r     <= '0;
            state_r <= (link.job.n == '0) ? S_LAST : S_L1;
          end
        end
        S_L1: begin
          for (int c = 0; c < 3; c++) begin
            a_r[c] <= lerp(job_r.pts[0][c], job_r.pts[1][c], t);
            b_r[c] <= lerp(job_r.pts[1][c], job_r.pts[2][c], t);
            e_r[c] <= lerp(job_r.pts[2][c], job_r.pts[3][c], t);
          end
          state_r <= S_L2;
        end
        S_L2: begin
          for (int c = 0; c < 3; c++) begin
            d_r[c] <= lerp(a_r[c], b_r[c], t);
            f_r[c] <= lerp(b_r[c], e_r[c], t);
          end
          state_r <= S_L3;
        end
        S_L3: begin
          for (int c = 0; c < 3; c++) cur_r[c] <= lerp(d_r[c], f_r[c], t);
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (slot_free) begin
            out_start <= prev_r;
            out_end   <= cur_r;
            out_color <= job_r.color;
            out_life  <= job_r.life;
            out_last  <= 1'b0;
            prev_r    <= cur_r;
            i_r       <= i_r + CntW'(1);
            t_r       <= t_r + job_r.q + TW'(wrap);
            racc_r    <= wrap ? CntW'(rsum - {1'b0, job_r.n}) : rsum[CntW-1:0];
            state_r   <= (i_r + CntW'(1) == job_r.n) ? S_LAST : S_L1;
          end
        end
        S_LAST: begin
          if (slot_free) begin
            out_start <= prev_r;
            out_end   <= job_r.pts[3];
            out_color <= job_r.color;
            out_life  <= job_r.life;
            out_last  <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/cubic_bezier_line_tessellator.sv @@
// Cubic Bezier tessellator: each item of four Q16.16 control points yields
// segment_count + 1 lines, the last one marked, or none while drawing is
// disabled. The evaluation unit computes each curve point level by level
// (de Casteljau levels S_L1, S_L2, S_L3) and then emits it once the output
// slot is free; the default is 16 segments. A write to segment_count starts
// a bit-serial step division, during which in_full is high.
module cubic_bezier_line_tessellator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_p0_x, in_p0_y, in_p0_z,
  input  logic signed [31:0] in_p1_x, in_p1_y, in_p1_z,
  input  logic signed [31:0] in_p2_x, in_p2_y, in_p2_z,
  input  logic signed [31:0] in_p3_x, in_p3_y, in_p3_z,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_start_x, out_start_y, out_start_z,
  output logic signed [31:0] out_end_x, out_end_y, out_end_z,
  output logic [31:0]        out_color_out,
  output logic [31:0]        out_lifetime_out,
  output logic               out_last_line
);
  import clb_pkg::*;

  vec_t [3:0] pts;
  job_link_t  link;
  logic       link_pop;
  vec_t       st, en;

  assign pts[0] = {in_p0_z, in_p0_y, in_p0_x};
  assign pts[1] = {in_p1_z, in_p1_y, in_p1_x};
  assign pts[2] = {in_p2_z, in_p2_y, in_p2_x};
  assign pts[3] = {in_p3_z, in_p3_y, in_p3_x};

  clb_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .push(in_push), .full(in_full), .pts, .link, .link_pop
  );

  clb_back u_back (
    .clk, .rst_n, .link, .link_pop, .out_empty, .out_pop,
    .out_start(st), .out_end(en), .out_color(out_color_out),
    .out_life(out_lifetime_out), .out_last(out_last_line)
  );

  assign out_start_x = st[0];
  assign out_start_y = st[1];
  assign out_start_z = st[2];
  assign out_end_x   = en[0];
  assign out_end_y   = en[1];
  assign out_end_z   = en[2];

endmodule
